// ===== design/itn_pkg.sv =====
package itn_pkg;

    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int RES_MAX    = 6;
    localparam int RES_W      = $clog2(RES_MAX + 1);
    localparam int SLOT_W     = $clog2(RES_MAX);

    // Input stalls while more bytes than this wait, so a full flush always fits.
    localparam logic [CNT_W-1:0] FILL_LIMIT = CNT_W'(FIFO_DEPTH - RES_MAX);

    localparam logic REG_FOLD_EVERYTHING = 1'b0;
    localparam logic REG_FREE_ALPHA      = 1'b1;

    localparam logic [1:0] HOLD_NONE = 2'd0;
    localparam logic [1:0] HOLD_ONE  = 2'd1;
    localparam logic [1:0] HOLD_TWO  = 2'd2;

    localparam logic [7:0] C_NUL   = 8'h00;
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_QUOTE = 8'h27;
    localparam logic [7:0] C_PLUS  = 8'h2B;
    localparam logic [7:0] C_MINUS = 8'h2D;
    localparam logic [7:0] C_DOT   = 8'h2E;
    localparam logic [7:0] C_ZERO  = 8'h30;
    localparam logic [7:0] C_NINE  = 8'h39;
    localparam logic [7:0] C_COLON = 8'h3A;
    localparam logic [7:0] C_SEMI  = 8'h3B;
    localparam logic [7:0] C_EQ    = 8'h3D;
    localparam logic [7:0] C_QUEST = 8'h3F;
    localparam logic [7:0] C_AT    = 8'h40;
    localparam logic [7:0] C_UNDER = 8'h5F;
    localparam logic [7:0] C_LOW_A = 8'h61;
    localparam logic [7:0] C_LOW_E = 8'h65;
    localparam logic [7:0] C_LOW_S = 8'h73;
    localparam logic [7:0] C_AE    = 8'hE6;
    localparam logic [7:0] C_SHARP = 8'hDF;

    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
        logic       two;
        logic       dotted;
    } t_dec_res;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= C_ZERO) && (c <= C_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_digit(c) || is_alpha(c);
    endfunction

    // Returns the base letter of a Latin-1 accented letter, or zero.
    function automatic logic [7:0] fold_accent(input logic [7:0] c);
        logic [7:0] f;
        f = C_NUL;
        case (c) inside
            [8'hE0:8'hE5]:        f = 8'h61;
            8'hE7:                f = 8'h63;
            [8'hE8:8'hEB]:        f = 8'h65;
            [8'hEC:8'hEF]:        f = 8'h69;
            8'hF1:                f = 8'h6E;
            [8'hF2:8'hF6], 8'hF8: f = 8'h6F;
            [8'hF9:8'hFC]:        f = 8'h75;
            8'hFD, 8'hFF:         f = 8'h79;
            [8'hC0:8'hC6]:        f = 8'h41;
            8'hC7:                f = 8'h43;
            [8'hC8:8'hCB]:        f = 8'h45;
            [8'hCC:8'hCF]:        f = 8'h49;
            8'hD1:                f = 8'h4E;
            [8'hD2:8'hD6], 8'hD8: f = 8'h4F;
            [8'hD9:8'hDC]:        f = 8'h55;
            8'hDD:                f = 8'h59;
            default:              f = C_NUL;
        endcase
        return f;
    endfunction

endpackage

// ===== design/itn_decide.sv =====
module itn_decide import itn_pkg::*; (
    input  logic [7:0] i_ch,
    input  logic [7:0] i_prev,
    input  logic [7:0] i_next,
    input  logic [7:0] i_after,
    input  logic       i_dotted,
    input  logic       i_full,
    output t_dec_res   o_res
);

    logic       w_punct;
    logic       w_word_sym;
    logic       w_eq_keep;
    logic [7:0] w_fold;

    always_comb begin
        w_punct = ((i_ch < C_ZERO) && (i_ch != C_MINUS) && (i_ch != C_QUOTE))
               || (i_ch == C_COLON) || (i_ch == C_SEMI) || (i_ch == C_QUEST);
        w_word_sym = (i_ch == C_MINUS) || (i_ch == C_AT) || (i_ch == C_UNDER)
                  || (i_ch == C_QUOTE) || is_alnum(i_ch);
        w_eq_keep = (i_ch == C_EQ) && is_alpha(i_prev)
                 && (is_digit(i_next)
                     || (((i_next == C_MINUS) || (i_next == C_PLUS)) && is_digit(i_after)));
        w_fold = fold_accent(i_ch);
    end

    always_comb begin
        o_res.first  = i_ch;
        o_res.second = i_ch;
        o_res.two    = 1'b0;
        o_res.dotted = i_dotted;
        if ((i_ch == C_DOT) && is_alnum(i_prev) && is_alnum(i_next)) begin
            o_res.dotted = 1'b1;
        end else if ((i_ch == C_DOT) && i_dotted) begin
            o_res.dotted = 1'b1;
        end else if (w_eq_keep) begin
            o_res.first = i_ch;
        end else if (w_punct) begin
            o_res.first  = C_SPACE;
            o_res.dotted = 1'b0;
        end else if (i_full) begin
            if (w_word_sym) begin
                o_res.first = i_ch;
            end else if (w_fold != C_NUL) begin
                o_res.first = w_fold;
            end else if (i_ch == C_AE) begin
                o_res.first  = C_LOW_A;
                o_res.second = C_LOW_E;
                o_res.two    = 1'b1;
            end else if (i_ch == C_SHARP) begin
                o_res.first  = C_LOW_S;
                o_res.second = C_LOW_S;
                o_res.two    = 1'b1;
            end else begin
                o_res.first  = C_SPACE;
                o_res.dotted = 1'b0;
            end
        end
    end

endmodule

// ===== design/index_text_normalizer_top.sv =====
// Cleans ISO-8859-1 text for word indexing, one byte per request. An accepted byte sits in an
// input register and is decided there against the bytes held for two-byte lookahead; its
// results go to an eight-byte output queue as it leaves. The block takes one byte per cycle
// while the queue has room and gives one per cycle while the output is ready; cleaned bytes
// trail the input by two bytes until the byte marked with tlast flushes the string (up to six
// bytes, tlast on the final one). A byte leaves the input register only while no more than two
// bytes wait in the queue, so a run of expanding letters or a flush briefly holds tready low
// until the queue drains. Registers take effect for every byte decided after the write.
module index_text_normalizer_top import itn_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic       i_cfg_data,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast
);

    logic             r_fold;
    logic             r_free;
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;
    logic [7:0]       r_prior;
    logic [7:0]       r_held1;
    logic [7:0]       r_held2;
    logic [1:0]       r_hcnt;
    logic             r_dotted;
    logic [7:0]       r_fbyte [FIFO_DEPTH];
    logic             r_flast [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    logic              w_full;
    logic              w_take;
    logic              w_pop;
    logic              w_accept;
    logic [7:0]        w_s0;
    logic [7:0]        w_s1;
    logic [7:0]        w_next0;
    logic [7:0]        w_after0;
    logic              w_e0;
    logic              w_e1;
    logic              w_e2;
    t_dec_res          w_d0;
    t_dec_res          w_d1;
    t_dec_res          w_d2;
    logic [SLOT_W-1:0] w_off1;
    logic [SLOT_W-1:0] w_off2;
    logic [RES_W-1:0]  w_wcnt;
    logic [7:0]        w_byte [RES_MAX];

    assign w_full        = r_fold && !r_free;
    assign w_take        = r_in_valid && (r_cnt <= FILL_LIMIT);
    assign s_axis_tready = !r_in_valid || w_take;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tdata  = r_fbyte[r_rptr];
    assign m_axis_tlast  = r_flast[r_rptr];
    assign w_pop         = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold <= 1'b1;
            r_free <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FOLD_EVERYTHING: r_fold <= i_cfg_data;
                REG_FREE_ALPHA:      r_free <= i_cfg_data;
                default:             r_fold <= r_fold;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // The string in decision order is held1, held2, new byte, as far as they exist.
    always_comb begin
        w_s0     = (r_hcnt != HOLD_NONE) ? r_held1 : r_in_byte;
        w_s1     = (r_hcnt == HOLD_TWO) ? r_held2 : r_in_byte;
        w_next0  = (r_hcnt != HOLD_NONE) ? w_s1 : C_NUL;
        w_after0 = (r_hcnt == HOLD_TWO) ? r_in_byte : C_NUL;
        w_e0     = r_in_last || (r_hcnt == HOLD_TWO);
        w_e1     = r_in_last && (r_hcnt != HOLD_NONE);
        w_e2     = r_in_last && (r_hcnt == HOLD_TWO);
    end

    itn_decide u_dec0 (
        .i_ch     (w_s0),
        .i_prev   (r_prior),
        .i_next   (w_next0),
        .i_after  (w_after0),
        .i_dotted (r_dotted),
        .i_full   (w_full),
        .o_res    (w_d0)
    );

    itn_decide u_dec1 (
        .i_ch     (w_s1),
        .i_prev   (w_s0),
        .i_next   (w_after0),
        .i_after  (C_NUL),
        .i_dotted (w_d0.dotted),
        .i_full   (w_full),
        .o_res    (w_d1)
    );

    itn_decide u_dec2 (
        .i_ch     (r_in_byte),
        .i_prev   (w_s1),
        .i_next   (C_NUL),
        .i_after  (C_NUL),
        .i_dotted (w_d1.dotted),
        .i_full   (w_full),
        .o_res    (w_d2)
    );

    always_comb begin
        w_off1 = w_e0 ? (w_d0.two ? SLOT_W'(2) : SLOT_W'(1)) : '0;
        w_off2 = w_off1 + (w_e1 ? (w_d1.two ? SLOT_W'(2) : SLOT_W'(1)) : SLOT_W'(0));
        w_wcnt = RES_W'(w_off2) + (w_e2 ? (w_d2.two ? RES_W'(2) : RES_W'(1)) : RES_W'(0));
        for (int k = 0; k < RES_MAX; k++) begin
            w_byte[k] = C_NUL;
        end
        if (w_e0) begin
            w_byte[0] = w_d0.first;
            w_byte[1] = w_d0.second;
        end
        if (w_e1) begin
            w_byte[w_off1]                  = w_d1.first;
            w_byte[w_off1 + SLOT_W'(1)]     = w_d1.second;
        end
        if (w_e2) begin
            w_byte[w_off2]                  = w_d2.first;
            w_byte[w_off2 + SLOT_W'(1)]     = w_d2.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior  <= '0;
            r_hcnt   <= HOLD_NONE;
            r_dotted <= 1'b0;
        end else if (w_take) begin
            if (r_in_last) begin
                r_prior  <= '0;
                r_hcnt   <= HOLD_NONE;
                r_dotted <= 1'b0;
            end else begin
                case (r_hcnt)
                    HOLD_NONE: r_hcnt <= HOLD_ONE;
                    HOLD_ONE:  r_hcnt <= HOLD_TWO;
                    default: begin
                        r_prior  <= r_held1;
                        r_dotted <= w_d0.dotted;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && !r_in_last) begin
            case (r_hcnt)
                HOLD_NONE: r_held1 <= r_in_byte;
                HOLD_ONE:  r_held2 <= r_in_byte;
                default: begin
                    r_held1 <= r_held2;
                    r_held2 <= r_in_byte;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            for (int k = 0; k < RES_MAX; k++) begin
                if (RES_W'(k) < w_wcnt) begin
                    r_fbyte[r_wptr + PTR_W'(k)] <= w_byte[k];
                    r_flast[r_wptr + PTR_W'(k)] <= r_in_last && (RES_W'(k + 1) == w_wcnt);
                end
            end
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (w_take) begin
            n_cnt = n_cnt + CNT_W'(w_wcnt);
        end
        if (w_pop) begin
            n_cnt = n_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_take) begin
                r_wptr <= r_wptr + PTR_W'(w_wcnt);
            end
            if (w_pop) begin
                r_rptr <= r_rptr + PTR_W'(1);
            end
        end
    end

endmodule

// ===== design/itn_checker.sv =====
module itn_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    // Reset leaves the output queue empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output changed");

    // The input only stalls behind bytes that are waiting to leave.
    a_stall_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with nothing waiting at the output");

    // Control bytes below the space are always replaced.
    a_no_control: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:5] != 3'b000))
        else $error("control byte passed to the output");

endmodule

bind index_text_normalizer_top itn_checker u_itn_checker (.*);

// ===== test/text_clean_check_pkg.sv =====
package text_clean_check_pkg;
    timeunit 1ns;
    timeprecision 1ps;

    import itn_pkg::*;

    typedef struct packed {
        logic [7:0] text;
        logic       last;
    } clean_out_t;

    class text_clean_board;
        bit          full_clean;
        bit          keep_high;
        logic [7:0]  seen_byte;
        logic [7:0]  wait_first;
        logic [7:0]  wait_second;
        int unsigned wait_count;
        bit          in_dotted;
        clean_out_t  cleaned_due[$];
        int unsigned errors;

        function new();
            full_clean  = 1'b1;
            keep_high   = 1'b0;
            seen_byte   = 8'h00;
            wait_first  = 8'h00;
            wait_second = 8'h00;
            wait_count  = 0;
            in_dotted   = 1'b0;
            errors      = 0;
        endfunction

        function void set_reg(logic idx, bit value);
            if (idx == REG_FOLD_EVERYTHING) begin
                full_clean = value;
            end else begin
                keep_high = value;
            end
        endfunction

        function int pending();
            return cleaned_due.size();
        endfunction

        function bit digit_ch(logic [7:0] c);
            return c >= C_ZERO && c <= C_NINE;
        endfunction

        function bit letter_ch(logic [7:0] c);
            return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
        endfunction

        function bit word_ch(logic [7:0] c);
            return digit_ch(c) || letter_ch(c);
        endfunction

        // Upper-case accents sit 0x20 below their lower-case forms, so both share one table.
        function logic [7:0] plain_letter(logic [7:0] c);
            logic [7:0] low;
            logic [7:0] base;
            if (c == 8'hFF) return 8'h79;
            if (c == 8'hC6) return 8'h41;
            if (c < 8'hC0 || c == C_SHARP) return C_NUL;
            low = c | 8'h20;
            if (low <= 8'hE5) base = 8'h61;
            else if (low == 8'hE7) base = 8'h63;
            else if (low >= 8'hE8 && low <= 8'hEB) base = 8'h65;
            else if (low >= 8'hEC && low <= 8'hEF) base = 8'h69;
            else if (low == 8'hF1) base = 8'h6E;
            else if ((low >= 8'hF2 && low <= 8'hF6) || low == 8'hF8) base = 8'h6F;
            else if (low >= 8'hF9 && low <= 8'hFC) base = 8'h75;
            else if (low == 8'hFD) base = 8'h79;
            else base = C_NUL;
            if (base != C_NUL && !c[5]) base = base - 8'h20;
            return base;
        endfunction

        function void emit_byte(logic [7:0] b);
            clean_out_t e;
            e.text = b;
            e.last = 1'b0;
            cleaned_due.push_back(e);
        endfunction

        function void emit_blank();
            emit_byte(C_SPACE);
            in_dotted = 1'b0;
        endfunction

        function void clean_byte(logic [7:0] ch, logic [7:0] nx, logic [7:0] af);
            logic [7:0] prev;
            logic [7:0] base;
            prev = seen_byte;
            seen_byte = ch;
            if (ch == C_DOT) begin
                if (word_ch(prev) && word_ch(nx)) begin
                    in_dotted = 1'b1;
                    emit_byte(ch);
                    return;
                end
                if (in_dotted) begin
                    emit_byte(ch);
                    return;
                end
            end
            if (ch == C_EQ && letter_ch(prev) &&
                (digit_ch(nx) || ((nx == C_MINUS || nx == C_PLUS) && digit_ch(af)))) begin
                emit_byte(ch);
                return;
            end
            if ((ch < C_ZERO && ch != C_MINUS && ch != C_UNDER && ch != C_AT && ch != C_QUOTE) ||
                ch == C_COLON || ch == C_SEMI || ch == C_QUEST) begin
                emit_blank();
                return;
            end
            if (full_clean && !keep_high) begin
                if (ch == C_MINUS || ch == C_AT || ch == C_UNDER || ch == C_QUOTE || word_ch(ch)) begin
                    emit_byte(ch);
                    return;
                end
                base = plain_letter(ch);
                if (base != C_NUL) begin
                    emit_byte(base);
                end else if (ch == C_AE) begin
                    emit_byte(C_LOW_A);
                    emit_byte(C_LOW_E);
                end else if (ch == C_SHARP) begin
                    emit_byte(C_LOW_S);
                    emit_byte(C_LOW_S);
                end else begin
                    emit_blank();
                end
                return;
            end
            emit_byte(ch);
        endfunction

        function void take_request(logic [7:0] b, logic l);
            logic [7:0]  row[3];
            int unsigned n;
            int unsigned k;
            int unsigned was;
            n = 0;
            if (wait_count >= 1) begin
                row[n] = wait_first;
                n++;
            end
            if (wait_count >= 2) begin
                row[n] = wait_second;
                n++;
            end
            row[n] = b;
            n++;
            if (!l) begin
                if (n == 3) begin
                    clean_byte(row[0], row[1], row[2]);
                    wait_first  = row[1];
                    wait_second = row[2];
                    wait_count  = 2;
                end else begin
                    wait_first = row[0];
                    if (n == 2) wait_second = row[1];
                    wait_count = n;
                end
                return;
            end
            was = cleaned_due.size();
            for (k = 0; k < n; k++) begin
                clean_byte(row[k], (k + 1 < n) ? row[k + 1] : C_NUL,
                           (k + 2 < n) ? row[k + 2] : C_NUL);
            end
            if (cleaned_due.size() > was) cleaned_due[cleaned_due.size() - 1].last = 1'b1;
            wait_count = 0;
            seen_byte  = C_NUL;
            in_dotted  = 1'b0;
        endfunction

        function void match_result(logic [7:0] b, logic l);
            clean_out_t want;
            if (cleaned_due.size() == 0) begin
                $display("%0t: unexpected byte %02h last %0b with nothing expected", $time, b, l);
                errors++;
                return;
            end
            want = cleaned_due.pop_front();
            if (want.text !== b) begin
                $display("%0t: out_byte expected %02h, actual %02h", $time, want.text, b);
                errors++;
            end
            if (want.last !== l) begin
                $display("%0t: out_last expected %0b, actual %0b", $time, want.last, l);
                errors++;
            end
        endfunction
    endclass

endpackage

// ===== test/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import itn_pkg::*;
    import text_clean_check_pkg::*;

    localparam logic [7:0] CAP_A = 8'h41;
    localparam logic [7:0] COMMA = 8'h2C;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_idx = 1'b0;
    logic       i_cfg_data = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;

    text_clean_board sb;
    int unsigned     send_idle_pct = 0;
    int unsigned     recv_idle_pct = 0;
    bit              hold_req = 1'b0;
    int unsigned     hold_left = 0;

    index_text_normalizer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.match_result(m_axis_tdata, m_axis_tlast);
        end
        if (hold_req) begin
            hold_left = 80;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [7:0] pick_char();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 25) return ($urandom_range(1) ? C_LOW_A : CAP_A) + 8'($urandom_range(25));
        if (r < 40) return C_ZERO + 8'($urandom_range(9));
        if (r < 52) return C_DOT;
        if (r < 60) return C_EQ;
        if (r < 68) return $urandom_range(1) ? C_PLUS : C_MINUS;
        if (r < 78) begin
            case ($urandom_range(7))
                0: return C_AT;
                1: return C_UNDER;
                2: return C_QUOTE;
                3: return C_COLON;
                4: return C_SEMI;
                5: return C_QUEST;
                6: return C_SPACE;
                default: return COMMA;
            endcase
        end
        if (r < 90) return 8'($urandom_range(255, 128));
        return 8'($urandom_range(255));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic l);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= l;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.take_request(b, l);
    endtask

    task automatic send_word(input string s, input bit close);
        int k;
        for (k = 0; k < s.len(); k++) begin
            send_byte(s[k], close && (k == s.len() - 1));
        end
    endtask

    task automatic random_run(input int unsigned budget, input bit leave_open);
        int unsigned sent;
        int unsigned len;
        int unsigned k;
        bit          close;
        sent = 0;
        while (sent < budget) begin
            len = $urandom_range(1, 10);
            close = !(leave_open && sent + len >= budget);
            for (k = 0; k < len; k++) begin
                send_byte(pick_char(), close && (k == len - 1));
            end
            sent += len;
        end
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic set_mode(input bit fold_on, input bit keep_on);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_FOLD_EVERYTHING;
        i_cfg_data <= fold_on;
        @(posedge i_clk);
        sb.set_reg(REG_FOLD_EVERYTHING, fold_on);
        i_cfg_idx  <= REG_FREE_ALPHA;
        i_cfg_data <= keep_on;
        @(posedge i_clk);
        sb.set_reg(REG_FREE_ALPHA, keep_on);
        i_cfg_we <= 1'b0;
    endtask

    // Bytes still held for lookahead give no result, so a short pause follows the drain.
    task automatic settle();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic run_phase(input bit fold_on, input bit keep_on, input int unsigned sidle,
                             input int unsigned ridle, input bit leave_open, input bit squeeze);
        settle();
        set_mode(fold_on, keep_on);
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        if (squeeze) hold_req = 1'b1;
        random_run(28, leave_open);
    endtask

    initial begin
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_mode(1'b1, 1'b0);
        send_idle_pct = 19;
        recv_idle_pct = 62;

        send_byte(8'h00, 1'b1);
        send_word("x=5", 1'b1);
        send_word("k=-7", 1'b1);
        send_word("v.1.", 1'b1);
        send_byte(C_AE, 1'b0);
        send_byte(C_SHARP, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hC0, 1'b1);
        send_word("q=+", 1'b1);
        send_word("@_'-?", 1'b1);
        s_axis_tvalid <= 1'b0;

        run_phase(1'b0, 1'b0, 19, 62, 1'b0, 1'b0);
        run_phase(1'b1, 1'b1, 19, 62, 1'b1, 1'b0);
        run_phase(1'b0, 1'b1, 62, 19, 1'b0, 1'b0);
        run_phase(1'b1, 1'b0, 62, 19, 1'b1, 1'b0);
        run_phase(1'b0, 1'b0, 0, 0, 1'b0, 1'b0);
        run_phase(1'b1, 1'b0, 0, 0, 1'b0, 1'b1);
        settle();

        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
